// File: rtl/core/acol_pkg.sv
// shared types and constants for the box collision table
`timescale 1ns / 1ps

package acol_pkg;

    localparam int ENTRIES = 32;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 16;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_MOVE   = 3'd2,
        OP_LIST   = 3'd3,
        OP_ANY    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_HIT      = 3'd3,
        STAT_NOHIT    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]         handle;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [11:0]        w;
        logic [11:0]        h;
    } box_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic start;
        logic advance;
        logic rm_shift;
        logic mv_wr;
    } cell_ctl_t;

    // what the cell holding the scan token reports back
    typedef struct packed {
        logic       hit;
        logic       match;
        logic [7:0] handle;
    } cell_rpt_t;

endpackage

// File: rtl/core/acol_cell.sv
// one table slot: stored box, scan token and overlap test
`timescale 1ns / 1ps

module acol_cell import acol_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  box_t      query,
    input  logic      add_sel,
    input  logic      tok_seed,
    input  logic      tok_prev,
    input  logic      tok_next,
    input  box_t      next_box,
    output logic      tok,
    output box_t      box,
    output cell_rpt_t rpt
);

    logic tok_reg;
    logic tok_nxt;
    box_t box_reg;
    box_t box_next;

    logic               same;
    logic               ovl;
    logic signed [17:0] qx0, qx1, qy0, qy1;
    logic signed [17:0] bx0, bx1, by0, by1;

    function automatic logic signed [17:0] sx(logic signed [15:0] v);
        return {{2{v[15]}}, v};
    endfunction

    function automatic logic signed [17:0] ux(logic [11:0] v);
        return {6'b0, v};
    endfunction

    always_comb begin
        qx0 = sx(query.x);
        qy0 = sx(query.y);
        qx1 = qx0 + ux(query.w);
        qy1 = qy0 + ux(query.h);
        bx0 = sx(box_reg.x);
        by0 = sx(box_reg.y);
        bx1 = bx0 + ux(box_reg.w);
        by1 = by0 + ux(box_reg.h);
        ovl = (qx0 < bx1) && (qx1 > bx0) && (qy0 < by1) && (qy1 > by0);
        same = (box_reg.handle == query.handle);
    end

    always_comb begin
        tok_nxt = tok_reg;
        if (ctl.start) begin
            tok_nxt = tok_seed;
        end else if (ctl.advance) begin
            tok_nxt = tok_prev;
        end

        box_next = box_reg;
        if (add_sel) begin
            box_next = query;
        end else if (tok_next && ctl.advance && ctl.rm_shift) begin
            // close the gap left by the removed entry
            box_next = next_box;
        end else if (tok_reg && ctl.advance && ctl.mv_wr && same) begin
            box_next.x = query.x;
            box_next.y = query.y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
        end else begin
            tok_reg <= tok_nxt;
        end
    end

    always_ff @(posedge aclk) begin
        box_reg <= box_next;
    end

    assign tok        = tok_reg;
    assign box        = box_reg;
    assign rpt.match  = tok_reg && same;
    assign rpt.hit    = tok_reg && !same && ovl;
    assign rpt.handle = tok_reg ? box_reg.handle : 8'd0;

endmodule

// File: rtl/core/acol_ctrl.sv
// sequencer: entry count, scan walk, hit buffering and result register
`timescale 1ns / 1ps

module acol_ctrl import acol_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  op_t              in_op,
    input  box_t             in_box,
    input  cell_rpt_t        rpt,
    output cell_ctl_t        ctl,
    output logic             add_wr,
    output box_t             query,
    output logic [CNT_W-1:0] count,
    output logic             m_tvalid,
    input  logic             m_tready,
    output status_t          m_status,
    output logic [7:0]       m_handle,
    output logic             m_last
);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    box_t             q_reg, q_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             found_reg, found_next;
    logic             full_reg, full_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [7:0]       pend_hdl_reg, pend_hdl_next;
    logic             m_vld_reg, m_vld_next;
    status_t          m_stat_reg, m_stat_next;
    logic [7:0]       m_hdl_reg, m_hdl_next;
    logic             m_last_reg, m_last_next;

    logic out_free;
    logic is_query;
    logic scan_end;
    logic rec;
    logic emit_mid;
    logic advance;
    logic start;

    always_comb begin
        out_free = !m_vld_reg || m_tready;
        is_query = (op_reg == OP_LIST) || (op_reg == OP_ANY);
        scan_end = (scan_reg == count_reg);
        // an any query keeps only its first hit
        rec      = is_query && rpt.hit && ((op_reg == OP_LIST) || !pend_vld_reg);
        // a newer hit means the buffered one is not the last
        emit_mid = rec && pend_vld_reg;
        advance  = (state_reg == S_SCAN) && !scan_end && (!emit_mid || out_free);
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        q_next        = q_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        found_next    = found_reg;
        full_next     = full_reg;
        pend_vld_next = pend_vld_reg;
        pend_hdl_next = pend_hdl_reg;
        m_vld_next    = m_vld_reg && !m_tready;
        m_stat_next   = m_stat_reg;
        m_hdl_next    = m_hdl_reg;
        m_last_next   = m_last_reg;
        s_tready      = 1'b0;
        add_wr        = 1'b0;
        start         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next = in_op;
                    q_next  = in_box;
                    case (in_op)
                        OP_ADD: begin
                            state_next = S_ADD;
                        end
                        OP_REMOVE, OP_MOVE, OP_LIST, OP_ANY: begin
                            start         = 1'b1;
                            scan_next     = '0;
                            found_next    = 1'b0;
                            pend_vld_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (count_reg == CNT_W'(ENTRIES)) begin
                    full_next = 1'b1;
                end else begin
                    full_next  = 1'b0;
                    add_wr     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_SCAN: begin
                if (scan_end) begin
                    if ((op_reg == OP_REMOVE) && found_reg) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = S_DONE;
                end else if (advance) begin
                    scan_next = scan_reg + CNT_W'(1);
                    if (rpt.match) begin
                        found_next = 1'b1;
                    end
                    if (rec) begin
                        pend_vld_next = 1'b1;
                        pend_hdl_next = rpt.handle;
                    end
                    if (emit_mid) begin
                        m_vld_next  = 1'b1;
                        m_stat_next = STAT_HIT;
                        m_hdl_next  = pend_hdl_reg;
                        m_last_next = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_vld_next  = 1'b1;
                    m_last_next = 1'b1;
                    m_hdl_next  = 8'd0;
                    case (op_reg)
                        OP_ADD: begin
                            m_stat_next = full_reg ? STAT_FULL : STAT_OK;
                        end
                        OP_REMOVE, OP_MOVE: begin
                            m_stat_next = found_reg ? STAT_OK : STAT_NOTFOUND;
                        end
                        OP_LIST, OP_ANY: begin
                            m_stat_next = pend_vld_reg ? STAT_HIT : STAT_NOHIT;
                            m_hdl_next  = pend_vld_reg ? pend_hdl_reg : 8'd0;
                        end
                        default: begin
                            m_stat_next = STAT_OK;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_vld_reg <= pend_vld_next;
            found_reg    <= found_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        q_reg        <= q_next;
        scan_reg     <= scan_next;
        full_reg     <= full_next;
        pend_hdl_reg <= pend_hdl_next;
        m_stat_reg   <= m_stat_next;
        m_hdl_reg    <= m_hdl_next;
        m_last_reg   <= m_last_next;
    end

    assign ctl.start    = start;
    assign ctl.advance  = advance;
    assign ctl.rm_shift = (op_reg == OP_REMOVE) && found_reg;
    assign ctl.mv_wr    = (op_reg == OP_MOVE) && !found_reg;
    assign query        = q_reg;
    assign count        = count_reg;
    assign m_tvalid     = m_vld_reg;
    assign m_status     = m_stat_reg;
    assign m_handle     = m_hdl_reg;
    assign m_last       = m_last_reg;

endmodule

// File: rtl/core/aabb_collision_table.sv
// top level: ordered box table built as a row of cells walked by a scan token
//
//   channel  dir  tdata bits (low to high)                          tlast
//   s_       in   op[2:0] handle[10:3] pos_x[26:11] pos_y[42:27]     -
//                 box_w[54:43] box_h[66:55], zero to 72 bits
//   m_       out  status[2:0] hit_handle[10:3], zero to 16 bits      last
//
// one item at a time. add passes through S_ADD and S_DONE before the result register
// is loaded. remove, move and both queries walk the token over the stored entries,
// one cell a cycle while the walk is not held, then pass through S_DONE.
// a list query holds the walk while an earlier hit waits on m_tready.
// reset empties the table; cell contents are not cleared.
`timescale 1ns / 1ps

module aabb_collision_table import acol_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // op, handle, pos_x, pos_y, box_w, box_h
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // status, hit_handle
    output logic                m_tlast
);

    op_t              in_op;
    box_t             in_box;
    cell_ctl_t        ctl;
    cell_rpt_t        rpt_all;
    cell_rpt_t        rpt [ENTRIES];
    box_t             boxes [ENTRIES];
    logic [ENTRIES-1:0] tok;
    logic             add_wr;
    box_t             query;
    logic [CNT_W-1:0] count;
    status_t          m_status;
    logic [7:0]       m_handle;

    assign in_op         = op_t'(s_tdata[2:0]);
    assign in_box.handle = s_tdata[10:3];
    assign in_box.x      = s_tdata[26:11];
    assign in_box.y      = s_tdata[42:27];
    assign in_box.w      = s_tdata[54:43];
    assign in_box.h      = s_tdata[66:55];

    acol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (in_op),
        .in_box   (in_box),
        .rpt      (rpt_all),
        .ctl      (ctl),
        .add_wr   (add_wr),
        .query    (query),
        .count    (count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_status (m_status),
        .m_handle (m_handle),
        .m_last   (m_tlast)
    );

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic tok_prev;
        logic tok_next;
        box_t next_box;

        if (i == 0) begin : g_head
            assign tok_prev = 1'b0;
        end else begin : g_body
            assign tok_prev = tok[i-1];
        end

        if (i == ENTRIES - 1) begin : g_tail
            assign tok_next = 1'b0;
            assign next_box = boxes[i];
        end else begin : g_link
            assign tok_next = tok[i+1];
            assign next_box = boxes[i+1];
        end

        acol_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .query    (query),
            .add_sel  (add_wr && (count == CNT_W'(i))),
            .tok_seed (1'(i == 0)),
            .tok_prev (tok_prev),
            .tok_next (tok_next),
            .next_box (next_box),
            .tok      (tok[i]),
            .box      (boxes[i]),
            .rpt      (rpt[i])
        );
    end

    // only the cell holding the token reports anything
    always_comb begin
        rpt_all = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            rpt_all.hit    = rpt_all.hit | rpt[i].hit;
            rpt_all.match  = rpt_all.match | rpt[i].match;
            rpt_all.handle = rpt_all.handle | rpt[i].handle;
        end
    end

    assign m_tdata = {5'b0, m_handle, m_status};

endmodule

// File: dv/aabb_collision_table_test.sv
// self-checking testbench for the box collision table: directed rows, then random traffic around a full-table phase
`timescale 1ns / 1ps

module aabb_collision_table_test;
    import acol_pkg::*;

    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;

    typedef struct {
        status_t    status;
        logic [7:0] hit;
        logic       tlast_bit;
    } result_t;

    typedef struct {
        logic [2:0] op;
        box_t       b;
        bit         typed;
        status_t    status;
    } dir_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                calm     = 1'b0;

    // mirror of the table contents
    box_t    stored_box [ENTRIES];
    int      stored_count = 0;
    int      peak_count   = 0;

    result_t step_results[$];
    result_t awaited_results[$];
    dir_row_t directed[$];

    int mismatch_count = 0;
    int result_count   = 0;
    int item_count     = 0;
    int ignored_count  = 0;
    int hit_count      = 0;
    int nohit_count    = 0;
    int full_count     = 0;
    int notfound_count = 0;
    int idle_cycles    = 0;

    aabb_collision_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // op, handle, pos_x, pos_y, box_w, box_h
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // status, hit_handle
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic bit boxes_overlap(box_t a, box_t b);
        int ax, ay, aw, ah, bx, by, bw, bh;
        ax = a.x;
        ay = a.y;
        aw = a.w;
        ah = a.h;
        bx = b.x;
        by = b.y;
        bw = b.w;
        bh = b.h;
        return ax < bx + bw && ax + aw > bx && ay < by + bh && ay + ah > by;
    endfunction

    function automatic int find_stored(logic [7:0] hd);
        for (int i = 0; i < stored_count; i++) begin
            if (stored_box[i].handle == hd) return i;
        end
        return -1;
    endfunction

    // updates the mirror and leaves the results of one item in step_results
    task automatic apply_table_op(input logic [2:0] op, input box_t q);
        int idx;
        int n;
        step_results.delete();
        case (op)
            OP_ADD: begin
                if (stored_count >= ENTRIES) begin
                    step_results.push_back('{STAT_FULL, 8'h00, 1'b1});
                end else begin
                    stored_box[stored_count] = q;
                    stored_count++;
                    if (stored_count > peak_count) peak_count = stored_count;
                    step_results.push_back('{STAT_OK, 8'h00, 1'b1});
                end
            end
            OP_REMOVE, OP_MOVE: begin
                idx = find_stored(q.handle);
                if (idx < 0) begin
                    step_results.push_back('{STAT_NOTFOUND, 8'h00, 1'b1});
                end else begin
                    if (op == OP_MOVE) begin
                        stored_box[idx].x = q.x;
                        stored_box[idx].y = q.y;
                    end else begin
                        for (int i = idx; i + 1 < stored_count; i++)
                            stored_box[i] = stored_box[i + 1];
                        stored_count--;
                    end
                    step_results.push_back('{STAT_OK, 8'h00, 1'b1});
                end
            end
            OP_LIST, OP_ANY: begin
                n = 0;
                for (int i = 0; i < stored_count; i++) begin
                    if (stored_box[i].handle != q.handle && boxes_overlap(q, stored_box[i]))
                    begin
                        if (op == OP_LIST || n == 0) begin
                            step_results.push_back('{STAT_HIT, stored_box[i].handle, 1'b0});
                            n++;
                        end
                    end
                end
                if (n == 0) step_results.push_back('{STAT_NOHIT, 8'h00, 1'b1});
                else step_results[n - 1].tlast_bit = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // one transfer on the input side, then prediction
    task automatic send_item(input logic [2:0] op, input box_t b, input bit typed,
                             input status_t st);
        bit gap;
        gap = !calm && ($urandom_range(99) < 27);
        if (gap) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 27);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, b.h, b.w, b.y, b.x, b.handle, op};
        do @(posedge aclk); while (!s_tready);
        item_count++;
        apply_table_op(op, b);
        if (step_results.size() == 0) ignored_count++;
        if (typed) begin
            awaited_results.push_back('{st, 8'h00, 1'b1});
        end else begin
            foreach (step_results[i]) awaited_results.push_back(step_results[i]);
        end
    endtask

    function automatic dir_row_t row(logic [2:0] op, logic [7:0] hd, int x, int y,
                                     int w, int h, bit typed, status_t st);
        dir_row_t r;
        r.op       = op;
        r.b.handle = hd;
        r.b.x      = 16'(x);
        r.b.y      = 16'(y);
        r.b.w      = 12'(w);
        r.b.h      = 12'(h);
        r.typed    = typed;
        r.status   = st;
        return r;
    endfunction

    function automatic box_t random_box(bit near);
        box_t b;
        b.handle = 8'h00;
        if (near) begin
            b.x = 16'(int'($urandom_range(1023)) - 512);
            b.y = 16'(int'($urandom_range(1023)) - 512);
            b.w = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(300));
            b.h = ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(300));
        end else begin
            b.x = 16'($urandom_range(65535));
            b.y = 16'($urandom_range(65535));
            b.w = 12'($urandom_range(4095));
            b.h = 12'($urandom_range(4095));
        end
        return b;
    endfunction

    // small handle pool so duplicates and self-skips actually happen
    function automatic logic [7:0] pick_handle(bit prefer_stored);
        if (prefer_stored && stored_count > 0 && $urandom_range(4) != 0)
            return stored_box[$urandom_range(stored_count - 1)].handle;
        if ($urandom_range(3) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(15));
    endfunction

    task automatic send_mixed(input int add_pct);
        int         r;
        logic [2:0] op;
        box_t       b;
        r = $urandom_range(99);
        if (r < add_pct) op = OP_ADD;
        else if (r < add_pct + 20) op = OP_REMOVE;
        else if (r < add_pct + 35) op = OP_MOVE;
        else if (r < add_pct + 60) op = OP_LIST;
        else if (r < 95) op = OP_ANY;
        else op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        b = random_box($urandom_range(9) != 0);
        b.handle = pick_handle(op != OP_ADD);
        send_item(op, b, 1'b0, STAT_OK);
    endtask

    // result side: random backpressure and comparison with the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 27);
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result %0d (status %0d) with nothing awaited",
                                          result_count, m_tdata[2:0]));
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              result_count, m_tdata[2:0], want.status));
                if (m_tdata[10:3] !== want.hit)
                    report_mismatch($sformatf("result %0d hit_handle %0h, want %0h",
                                              result_count, m_tdata[10:3], want.hit));
                if (m_tlast !== want.tlast_bit)
                    report_mismatch($sformatf("result %0d tlast %0b, want %0b",
                                              result_count, m_tlast, want.tlast_bit));
                case (want.status)
                    STAT_HIT:      hit_count++;
                    STAT_NOHIT:    nohit_count++;
                    STAT_FULL:     full_count++;
                    STAT_NOTFOUND: notfound_count++;
                    default: ;
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("timeout with %0d results still awaited", awaited_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        box_t b;

        directed.push_back(row(OP_REMOVE, 8'h05, 0, 0, 0, 0, 1, STAT_NOTFOUND));
        directed.push_back(row(OP_MOVE, 8'h05, 32767, -32768, 1, 1, 1, STAT_NOTFOUND));
        directed.push_back(row(OP_LIST, 8'h01, -2048, -2048, 4095, 4095, 1, STAT_NOHIT));
        directed.push_back(row(OP_ANY, 8'h01, -2048, -2048, 4095, 4095, 1, STAT_NOHIT));
        directed.push_back(row(OP_ADD, 8'h00, -32768, -32768, 4095, 4095, 1, STAT_OK));
        directed.push_back(row(OP_ADD, 8'hFF, 32767, 32767, 4095, 4095, 1, STAT_OK));
        directed.push_back(row(OP_ADD, 8'h20, 0, 0, 0, 0, 1, STAT_OK));
        directed.push_back(row(OP_ADD, 8'h10, -100, -100, 200, 200, 1, STAT_OK));
        // same handle twice on purpose
        directed.push_back(row(OP_ADD, 8'h10, 50, 50, 10, 10, 1, STAT_OK));
        directed.push_back(row(OP_ADD, 8'h30, 100, 100, 50, 50, 1, STAT_OK));
        directed.push_back(row(OP_LIST, 8'h01, -32768, -32768, 4095, 4095, 0, STAT_OK));
        directed.push_back(row(OP_LIST, 8'h01, -10, -10, 200, 200, 0, STAT_OK));
        directed.push_back(row(OP_LIST, 8'h10, -10, -10, 200, 200, 0, STAT_OK));
        directed.push_back(row(OP_ANY, 8'h01, 32000, 32000, 4095, 4095, 0, STAT_OK));
        // zero-size query strictly inside a stored box still overlaps it
        directed.push_back(row(OP_LIST, 8'h01, 0, 0, 0, 0, 0, STAT_OK));
        // edges that only touch do not count, a one-unit overlap does
        directed.push_back(row(OP_ANY, 8'h01, 150, 100, 10, 10, 0, STAT_OK));
        directed.push_back(row(OP_ANY, 8'h01, 149, 149, 1, 1, 0, STAT_OK));
        directed.push_back(row(OP_MOVE, 8'h10, 1000, 1000, 1, 1, 1, STAT_OK));
        directed.push_back(row(OP_UNUSED_LO, 8'hAA, 5, 5, 5, 5, 0, STAT_OK));
        directed.push_back(row(OP_UNUSED_HI, 8'h55, -5, -5, 4095, 0, 0, STAT_OK));
        directed.push_back(row(OP_REMOVE, 8'h10, 0, 0, 0, 0, 1, STAT_OK));
        directed.push_back(row(OP_REMOVE, 8'h10, 0, 0, 0, 0, 1, STAT_OK));
        directed.push_back(row(OP_REMOVE, 8'h10, 0, 0, 0, 0, 1, STAT_NOTFOUND));
        directed.push_back(row(OP_LIST, 8'h02, -32768, -32768, 4095, 4095, 0, STAT_OK));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].op, directed[i].b, directed[i].typed, directed[i].status);

        repeat (30) send_mixed(30);

        // fill the table with no idling, overflow it, then query an area covering every box the fill added
        calm <= 1'b1;
        while (stored_count < ENTRIES) begin
            b = random_box(1'b1);
            b.handle = 8'(8'h40 + stored_count);
            send_item(OP_ADD, b, 1'b0, STAT_OK);
        end
        b = random_box(1'b0);
        b.handle = 8'hC3;
        send_item(OP_ADD, b, 1'b1, STAT_FULL);
        send_item(OP_ADD, b, 1'b1, STAT_FULL);
        b = '{8'h00, -16'sd2048, -16'sd2048, 12'd4095, 12'd4095};
        send_item(OP_LIST, b, 1'b0, STAT_OK);
        send_item(OP_ANY, b, 1'b0, STAT_OK);
        calm <= 1'b0;

        repeat (20) send_mixed(15);

        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d items (%0d ignored op codes), %0d results, table peak %0d of %0d",
                 item_count, ignored_count, result_count, peak_count, ENTRIES);
        $display("statuses seen: %0d hit, %0d no hit, %0d full, %0d not found",
                 hit_count, nohit_count, full_count, notfound_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
